### sv/tsbr_pkg.sv
// tsbr_pkg: widths, constants, register indexes and FSM state type for
// the transport stream bit rate block. No dependencies.
`timescale 1ns / 1ps

package tsbr_pkg;

    localparam int PID_W      = 13;
    localparam int BASE_W     = 32;
    localparam int EXT_W      = 10;
    localparam int USEC_W     = 28;
    localparam int COUNT_W    = 32;
    localparam int BPS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Serial arithmetic works on the low 32 bits of the 27 MHz time only.
    localparam int TIME_W = 32;
    localparam int PROD_W = 64;

    localparam int PACKET_BYTES = 188;
    localparam longint MUL_K_L  = longint'(PACKET_BYTES) * 8 * 1000000;
    localparam int MUL_K_W      = 31;
    localparam logic [MUL_K_W-1:0] MUL_K = MUL_K_W'(MUL_K_L);

    localparam logic [PID_W-1:0] NULL_PID = 13'h1FFF;
    localparam int USEC_DIV = 27;

    localparam logic [CFG_IDX_W-1:0] REG_PID_FILTER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_NULL = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SER,
        S_DIV27,
        S_CHK,
        S_DIVR,
        S_OUT
    } state_t;

endpackage

### sv/tsbr_if.sv
// tsbr_if: valid/ready channel interfaces for packet input, rate output
// and configuration writes. Depends on tsbr_pkg.
`timescale 1ns / 1ps

interface tsbr_in_if
    import tsbr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PID_W-1:0]  pid;
    logic              has_pcr;
    logic [BASE_W-1:0] pcr_base_45k;
    logic [EXT_W-1:0]  pcr_extension;

    modport source (output valid, pid, has_pcr, pcr_base_45k, pcr_extension,
                    input ready);
    modport sink   (input valid, pid, has_pcr, pcr_base_45k, pcr_extension,
                    output ready);
endinterface

interface tsbr_out_if
    import tsbr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               rate_valid;
    logic               zero_interval;
    logic [USEC_W-1:0]  elapsed_usec;
    logic [COUNT_W-1:0] packets_counted;
    logic [BPS_W-1:0]   bits_per_second;

    modport source (output valid, rate_valid, zero_interval, elapsed_usec,
                    packets_counted, bits_per_second, input ready);
    modport sink   (input valid, rate_valid, zero_interval, elapsed_usec,
                    packets_counted, bits_per_second, output ready);
endinterface

interface tsbr_cfg_if
    import tsbr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

### sv/ts_bit_rate_between_pcr.sv
// ts_bit_rate_between_pcr: bit rate between PCRs of a transport stream,
// bit-serial datapath. Depends on tsbr_pkg and tsbr_if.
//
//  channel  | dir | transfer moves
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | pid, has_pcr, pcr_base_45k, pcr_extension (one packet)
//  out_ch   | out | rate_valid, zero_interval, elapsed_usec,
//           |     | packets_counted, bits_per_second
//  cfg_ch   | in  | idx, data (register write, always ready)
//
// A packet without a used PCR is taken in idle. A used PCR runs the serial
// 27 MHz time/difference pass and multiply; the first PCR ends there.
// Later PCRs add the divide by 27, a check state and the rate divide
// (skipped for a zero interval) before the result sits in the output
// register. The restoring dividers give one quotient bit a cycle. in_ch
// is ready only in idle; a stalled output holds the next result in the
// wait state. Reset (rst_n, async) clears the configuration registers,
// count, reference PCR and FSM.
`timescale 1ns / 1ps

module ts_bit_rate_between_pcr
    import tsbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tsbr_in_if.sink    in_ch,
    tsbr_out_if.source out_ch,
    tsbr_cfg_if.sink   cfg_ch
);

    // configuration
    logic [PID_W-1:0] pid_filter_reg;
    logic             exclude_null_reg;

    // control
    state_t state_reg, state_next;
    logic [5:0]          bit_cnt_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                prev_valid_reg;
    logic                go_result_reg;

    // serial datapath
    logic [BASE_W-1:0]  base_sr_reg;
    logic [EXT_W-1:0]   ext_sr_reg;
    logic [8:0]         dly_reg;      // dly_reg[k] = base bit i-1-k
    logic [2:0]         carry_reg;
    logic               borrow_reg;
    logic [TIME_W-1:0]  prev_sr_reg;  // reference time, replaced by the new time as it shifts
    logic [TIME_W-1:0]  diff_sr_reg;  // difference, then quotient (usec)
    logic [COUNT_W-1:0] count_sr_reg; // packet count, rotates through
    logic [PROD_W-1:0]  prod_reg;     // product, then rate quotient
    logic [USEC_W-1:0]  rem_reg;

    // output register
    logic               out_valid_reg;
    logic               out_zero_reg;
    logic [USEC_W-1:0]  out_usec_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [BPS_W-1:0]   out_bps_reg;

    logic in_fire, cfg_fire, pcr_used, out_load, phase_change;
    logic [COUNT_W-1:0] count_inc;
    logic last32, last64;

    // serial time / difference
    logic [3:0] ser_sum;
    logic       now_bit, prev_bit, diff_bit, borrow_next;
    // serial-parallel multiply
    logic [32:0] mul_hi;
    // divide by 27
    logic [5:0] d27_t;
    logic       d27_ge;
    logic [4:0] d27_rem;
    // rate divide
    logic [USEC_W:0]   dr_t, dr_div;
    logic              dr_ge;
    logic [USEC_W-1:0] dr_rem;

    logic usec_zero, rate_sat;
    logic [BPS_W-1:0] rate_val;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign pcr_used = in_ch.has_pcr
                      && (pid_filter_reg == '0 || in_ch.pid == pid_filter_reg);
    assign count_inc = count_reg
        + ((exclude_null_reg && in_ch.pid == NULL_PID) ? COUNT_W'(0) : COUNT_W'(1));

    assign last32 = (bit_cnt_reg[4:0] == 5'd31);
    assign last64 = (bit_cnt_reg == 6'd63);

    // LSB-first: now = base*600 + ext, 600 = 2^9 + 2^6 + 2^4 + 2^3
    assign ser_sum = 4'(dly_reg[2]) + 4'(dly_reg[3]) + 4'(dly_reg[5])
                   + 4'(dly_reg[8]) + 4'(ext_sr_reg[0]) + 4'(carry_reg);
    assign now_bit  = ser_sum[0];
    assign prev_bit = prev_sr_reg[0];
    assign diff_bit = now_bit ^ prev_bit ^ borrow_reg;
    assign borrow_next = (!now_bit && (prev_bit || borrow_reg))
                         || (prev_bit && borrow_reg);

    // count * MUL_K, one count bit a cycle, LSB first
    assign mul_hi = {1'b0, prod_reg[PROD_W-1:32]}
                  + (count_sr_reg[0] ? 33'(MUL_K) : 33'd0);

    // restoring divide by 27, MSB first
    assign d27_t   = {rem_reg[4:0], diff_sr_reg[TIME_W-1]};
    assign d27_ge  = (d27_t >= 6'(USEC_DIV));
    assign d27_rem = d27_ge ? 5'(d27_t - 6'(USEC_DIV)) : d27_t[4:0];

    // restoring divide of product by elapsed_usec
    assign dr_div = {1'b0, diff_sr_reg[USEC_W-1:0]};
    assign dr_t   = {rem_reg, prod_reg[PROD_W-1]};
    assign dr_ge  = (dr_t >= dr_div);
    assign dr_rem = dr_ge ? USEC_W'(dr_t - dr_div) : dr_t[USEC_W-1:0];

    assign usec_zero = (diff_sr_reg[USEC_W-1:0] == '0);
    assign rate_sat  = |prod_reg[PROD_W-1:32];
    assign rate_val  = usec_zero ? '0 : (rate_sat ? '1 : prod_reg[BPS_W-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && pcr_used)
                    state_next = S_SER;
            end
            S_SER:
            begin
                if (last32)
                    state_next = go_result_reg ? S_DIV27 : S_IDLE;
            end
            S_DIV27:
            begin
                if (last32)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = usec_zero ? S_OUT : S_DIVR;
            end
            S_DIVR:
            begin
                if (last64)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ch.ready  = (state_reg == S_IDLE);
        cfg_ch.ready = 1'b1;
        out_load     = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);
        phase_change = (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= phase_change ? 6'd0 : bit_cnt_reg + 6'd1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_filter_reg   <= '0;
            exclude_null_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_ch.idx)
                REG_PID_FILTER:   pid_filter_reg   <= cfg_ch.data[PID_W-1:0];
                REG_EXCLUDE_NULL: exclude_null_reg <= cfg_ch.data[0];
                default:          ;
            endcase
        end
    end

    // packet count and reference state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_valid_reg <= 1'b0;
            go_result_reg  <= 1'b0;
            prev_sr_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= pcr_used ? '0 : count_inc;
                if (pcr_used)
                begin
                    go_result_reg  <= prev_valid_reg;
                    prev_valid_reg <= 1'b1;
                end
            end
            if (state_reg == S_SER)
                prev_sr_reg <= {now_bit, prev_sr_reg[TIME_W-1:1]};
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                base_sr_reg  <= in_ch.pcr_base_45k;
                ext_sr_reg   <= in_ch.pcr_extension;
                count_sr_reg <= count_inc;
                dly_reg      <= '0;
                carry_reg    <= '0;
                borrow_reg   <= 1'b0;
                prod_reg     <= '0;
                rem_reg      <= '0;
            end
            S_SER:
            begin
                base_sr_reg  <= {1'b0, base_sr_reg[BASE_W-1:1]};
                ext_sr_reg   <= {1'b0, ext_sr_reg[EXT_W-1:1]};
                dly_reg      <= {dly_reg[7:0], base_sr_reg[0]};
                carry_reg    <= ser_sum[3:1];
                borrow_reg   <= borrow_next;
                diff_sr_reg  <= {diff_bit, diff_sr_reg[TIME_W-1:1]};
                prod_reg     <= {mul_hi, prod_reg[31:1]};
                count_sr_reg <= {count_sr_reg[0], count_sr_reg[COUNT_W-1:1]};
                rem_reg      <= '0;
            end
            S_DIV27:
            begin
                diff_sr_reg <= {diff_sr_reg[TIME_W-2:0], d27_ge};
                rem_reg     <= USEC_W'(d27_rem);
            end
            S_CHK:
            begin
                rem_reg <= '0;
            end
            S_DIVR:
            begin
                prod_reg <= {prod_reg[PROD_W-2:0], dr_ge};
                rem_reg  <= dr_rem;
            end
            S_OUT:
            begin
                rem_reg <= '0;
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_zero_reg  <= usec_zero;
            out_usec_reg  <= diff_sr_reg[USEC_W-1:0];
            out_count_reg <= count_sr_reg;
            out_bps_reg   <= rate_val;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.rate_valid      = !out_zero_reg;
    assign out_ch.zero_interval   = out_zero_reg;
    assign out_ch.elapsed_usec    = out_usec_reg;
    assign out_ch.packets_counted = out_count_reg;
    assign out_ch.bits_per_second = out_bps_reg;

endmodule

### verif/tb_ts_bit_rate_between_pcr.sv
// tb_ts_bit_rate_between_pcr: self-checking bench for the PCR bit rate block.
// Random gaps on the packet and rate channels; a built-in predictor.
// Depends on tsbr_pkg, tsbr_if and ts_bit_rate_between_pcr.
`timescale 1ns / 1ps

module tb_ts_bit_rate_between_pcr
    import tsbr_pkg::*;
;

    // Idle cycles with no transfer on any channel before the run is called hung.
    // Worst legit quiet stretch: phase pause + rate divide + long stall
    // + long source gap, well under IDLE_LIMIT.
    localparam int IDLE_LIMIT = 5000;
    // Cycles to let the block finish a PCR that produces no result.
    localparam int SETTLE = 200;
    localparam int PKTS_PER_PHASE = 270;
    localparam int MAX_REPORTS = 10;

    // 27 MHz time wraps where the 45 kHz base runs out of 32 bits.
    localparam bit [63:0] PCR_WRAP = 64'd600 << 32;
    // Bits per packet times microseconds per second.
    localparam bit [63:0] BIT_USEC_K = 64'(PACKET_BYTES) * 64'd8 * 64'd1000000;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic              has_pcr;
        logic [BASE_W-1:0] base;
        logic [EXT_W-1:0]  ext;
    } pkt_t;

    typedef struct packed {
        logic               rate_valid;
        logic               zero_interval;
        logic [USEC_W-1:0]  usec;
        logic [COUNT_W-1:0] count;
        logic [BPS_W-1:0]   bps;
    } rate_t;

    logic clk;
    logic rst_n;

    tsbr_in_if  pkt_if ();
    tsbr_out_if rate_if ();
    tsbr_cfg_if cfg_if ();

    ts_bit_rate_between_pcr DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (pkt_if),
        .out_ch (rate_if),
        .cfg_ch (cfg_if)
    );

    // Stimulus and expectation stores
    pkt_t  pkt_q[$];
    rate_t rate_q[$];
    int    pkts_pushed;
    int    pkts_taken;
    int    fail_count;

    // Predictor copy of the block's registers and state
    logic [PID_W-1:0] pid_sel_cfg;
    logic             excl_null_cfg;
    bit   [31:0]      pkt_count;
    bit   [41:0]      ref_27m;
    bit               ref_seen;

    // Source/sink pacing
    int gap_left;
    int src_burst;
    int stall_left;
    int sink_burst;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Known values on every block input from time zero; reset held, then released on a clock edge.
    initial
    begin
        rst_n                 = 1'b0;
        pkt_if.valid          = 1'b0;
        pkt_if.pid            = '0;
        pkt_if.has_pcr        = 1'b0;
        pkt_if.pcr_base_45k   = '0;
        pkt_if.pcr_extension  = '0;
        rate_if.ready         = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.idx            = '0;
        cfg_if.data           = '0;
        pid_sel_cfg           = '0;
        excl_null_cfg         = 1'b0;
        pkt_count             = '0;
        ref_27m               = '0;
        ref_seen              = 1'b0;
        pkts_pushed           = 0;
        pkts_taken            = 0;
        fail_count            = 0;
        gap_left              = 0;
        src_burst             = 0;
        stall_left            = 0;
        sink_burst            = 0;
        quiet_cycles          = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 90);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        else if (r < 90)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 200);
    endfunction

    // Expected result of one accepted packet, if any; updates predictor state.
    function automatic void predict_rate(input pkt_t p);
        bit [41:0] now_27m;
        bit [31:0] diff;
        bit [31:0] usec;
        bit [63:0] quo;
        rate_t     r;
        if (!(excl_null_cfg && p.pid == NULL_PID))
            pkt_count = pkt_count + 32'd1;
        if (pid_sel_cfg != '0 && p.pid != pid_sel_cfg)
            return;
        if (!p.has_pcr)
            return;
        now_27m = 42'(p.base) * 42'd600 + 42'(p.ext);
        if (ref_seen)
        begin
            // interval taken on the low 32 bits, so a backward PCR wraps
            diff = now_27m[31:0] - ref_27m[31:0];
            usec = diff / 32'(USEC_DIV);
            quo  = '0;
            if (usec != 0)
                quo = (64'(pkt_count) * BIT_USEC_K) / 64'(usec);
            r.rate_valid    = (usec != 0);
            r.zero_interval = (usec == 0);
            r.usec          = usec[USEC_W-1:0];
            r.count         = pkt_count;
            r.bps           = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
            rate_q.push_back(r);
        end
        ref_27m   = now_27m;
        ref_seen  = 1'b1;
        pkt_count = '0;
    endfunction

    function automatic void push_pkt(input logic [PID_W-1:0] pid, input logic has_pcr,
                                     input logic [BASE_W-1:0] base,
                                     input logic [EXT_W-1:0] ext);
        pkt_t p;
        p.pid     = pid;
        p.has_pcr = has_pcr;
        p.base    = base;
        p.ext     = ext;
        pkt_q.push_back(p);
        pkts_pushed++;
    endfunction

    // Register write: valid raised at an edge, held until the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every packet and every expected rate, then let a trailing
    // result-free PCR finish before touching the registers.
    task automatic drain();
        while (pkts_taken != pkts_pushed || rate_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly a realistic stream: PCRs on the selected PID from a running
    // 27 MHz clock, plain packets between them; the rest is noise.
    task automatic run_random_phase(input logic [PID_W-1:0] sel, input int n_pkts);
        bit [63:0]         t27;
        bit [63:0]         adv;
        logic [PID_W-1:0]  pid;
        logic [EXT_W-1:0]  ext;
        int                r;
        t27 = {$urandom, $urandom} % PCR_WRAP;
        for (int i = 0; i < n_pkts; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 16)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    adv = 64'd0;                            // zero interval
                else if (r < 16)
                    adv = 64'($urandom_range(1, 53));       // under 2 us
                else if (r < 85)
                    adv = 64'(27 * $urandom_range(50, 50000) + $urandom_range(0, 26));
                else if (r < 95)
                    adv = 64'($urandom);                    // long jump
                else
                begin
                    adv = 64'd0;                            // discontinuity
                    t27 = {$urandom, $urandom} % PCR_WRAP;
                end
                t27 = (t27 + adv) % PCR_WRAP;
                ext = EXT_W'(t27 % 600);
                if ($urandom_range(0, 19) == 0)
                    ext = EXT_W'($urandom_range(600, 1023)); // out-of-spec extension
                if (sel != '0)
                    pid = sel;
                else if ($urandom_range(0, 3) == 0)
                    pid = NULL_PID;
                else
                    pid = PID_W'($urandom);
                push_pkt(pid, 1'b1, BASE_W'(t27 / 600), ext);
            end
            else if (r < 30)
                push_pkt(PID_W'($urandom), 1'($urandom), $urandom, EXT_W'($urandom));
            else
            begin
                pid = ($urandom_range(0, 4) == 0) ? NULL_PID : PID_W'($urandom);
                push_pkt(pid, (sel != '0) && ($urandom_range(0, 2) == 0),
                         $urandom, EXT_W'($urandom));
            end
        end
    endtask

    // Stimulus sequence
    initial
    begin
        logic [PID_W-1:0] sel;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed, default registers: PCR on any PID, nulls counted.
        write_reg(REG_PID_FILTER, 0);
        write_reg(REG_EXCLUDE_NULL, 0);
        push_pkt(13'h0000, 1'b1, 32'h0000_0000, 10'd0);      // first PCR, no rate
        push_pkt(NULL_PID, 1'b0, 32'hFFFF_FFFF, 10'h3FF);    // counted null
        push_pkt(13'h0100, 1'b1, 32'h0000_0000, 10'd27);     // 1 us, 2 packets
        push_pkt(13'h0100, 1'b0, 32'h1234_5678, 10'd5);
        push_pkt(13'h0200, 1'b1, 32'h0000_0000, 10'd27);     // zero interval
        push_pkt(13'h0001, 1'b0, 32'h0, 10'd0);
        push_pkt(13'h0002, 1'b0, 32'h0, 10'd0);
        push_pkt(13'h0001, 1'b1, 32'h0000_0000, 10'd54);     // rate saturates
        push_pkt(NULL_PID, 1'b1, 32'hFFFF_FFFF, 10'h3FF);    // max base, ext > 599
        push_pkt(13'h0002, 1'b1, 32'h0000_0000, 10'd0);      // PCR goes backward
        push_pkt(13'h0003, 1'b1, 32'd45000, 10'd599);        // about one second
        push_pkt(13'h0AAA, 1'b1, 32'hAAAA_AAAA, 10'h2AA);
        push_pkt(13'h1555, 1'b1, 32'h5555_5555, 10'h155);
        drain();

        // Directed, null PID selected and left out of the count.
        write_reg(REG_PID_FILTER, 32'h0000_1FFF);
        write_reg(REG_EXCLUDE_NULL, 1);
        push_pkt(NULL_PID, 1'b1, 32'd100, 10'd0);            // nothing counted
        push_pkt(13'h0005, 1'b1, 32'd200, 10'd0);            // other PID: counted only
        push_pkt(NULL_PID, 1'b0, 32'd0, 10'd0);              // not counted
        push_pkt(NULL_PID, 1'b1, 32'd300, 10'd0);
        push_pkt(13'h0000, 1'b1, 32'd400, 10'd0);            // PID 0 filtered out
        push_pkt(NULL_PID, 1'b1, 32'd300, 10'd0);            // zero interval
        drain();

        // Random phases over a spread of register settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: sel = 13'h0000;
                1: sel = 13'h1FFF;
                2: sel = 13'h0001;
                4: sel = 13'h0000;
                default: sel = PID_W'($urandom_range(2, 8190));
            endcase
            write_reg(REG_PID_FILTER, 32'(sel));
            write_reg(REG_EXCLUDE_NULL, (ph == 1 || ph == 3 || ph == 4) ? 1 : 0);
            run_random_phase(sel, PKTS_PER_PHASE);
            drain();
        end

        fail_count += rate_q.size();
        if (fail_count == 0)
            $display("tb_ts_bit_rate_between_pcr: clean");
        else
            $display("tb_ts_bit_rate_between_pcr: errors");
        $finish;
    end

    // Packet driver: holds an item until its transfer, then idles for the
    // chosen gap. Bursts with no gaps show up now and then.
    always @(posedge clk)
    begin
        pkt_t p;
        if (rst_n && !(pkt_if.valid && !pkt_if.ready))
        begin
            if (gap_left != 0)
            begin
                pkt_if.valid <= 1'b0;
                gap_left--;
            end
            else if (pkt_q.size() != 0)
            begin
                p = pkt_q.pop_front();
                pkt_if.pid           <= p.pid;
                pkt_if.has_pcr       <= p.has_pcr;
                pkt_if.pcr_base_45k  <= p.base;
                pkt_if.pcr_extension <= p.ext;
                pkt_if.valid         <= 1'b1;
                if (src_burst != 0)
                    src_burst--;
                else if ($urandom_range(0, 99) == 0)
                    src_burst = $urandom_range(20, 60);
                gap_left = (src_burst != 0) ? 0 : pick_gap();
            end
            else
                pkt_if.valid <= 1'b0;
        end
    end

    // Rate sink: random stalls, with stretches of steady ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                rate_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rate_if.ready <= 1'b1;
                if (sink_burst != 0)
                    sink_burst--;
                else if ($urandom_range(0, 299) == 0)
                    sink_burst = $urandom_range(200, 600);
                else if ($urandom_range(0, 5) == 0)
                    stall_left = pick_stall();
            end
        end
    end

    // Monitor: register writes and packets feed the predictor; each rate
    // transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        pkt_t  p;
        rate_t got;
        rate_t exp_r;
        if (cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_if.idx)
                REG_PID_FILTER:   pid_sel_cfg   = cfg_if.data[PID_W-1:0];
                REG_EXCLUDE_NULL: excl_null_cfg = cfg_if.data[0];
                default: ;
            endcase
        end
        if (pkt_if.valid && pkt_if.ready)
        begin
            p.pid     = pkt_if.pid;
            p.has_pcr = pkt_if.has_pcr;
            p.base    = pkt_if.pcr_base_45k;
            p.ext     = pkt_if.pcr_extension;
            predict_rate(p);
            pkts_taken++;
        end
        if (rate_if.valid && rate_if.ready)
        begin
            got.rate_valid    = rate_if.rate_valid;
            got.zero_interval = rate_if.zero_interval;
            got.usec          = rate_if.elapsed_usec;
            got.count         = rate_if.packets_counted;
            got.bps           = rate_if.bits_per_second;
            if (rate_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: rate transfer with none expected: rv=%0d zi=%0d usec=%0d count=%0d bps=%0d",
                             $realtime, got.rate_valid, got.zero_interval, got.usec,
                             got.count, got.bps);
            end
            else
            begin
                exp_r = rate_q.pop_front();
                if (got.rate_valid !== exp_r.rate_valid
                    || got.zero_interval !== exp_r.zero_interval
                    || got.usec !== exp_r.usec
                    || got.count !== exp_r.count
                    || got.bps !== exp_r.bps)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: rate mismatch", $realtime);
                        $display("  expected rv=%0d zi=%0d usec=%0d count=%0d bps=%0d",
                                 exp_r.rate_valid, exp_r.zero_interval, exp_r.usec,
                                 exp_r.count, exp_r.bps);
                        $display("  actual   rv=%0d zi=%0d usec=%0d count=%0d bps=%0d",
                                 got.rate_valid, got.zero_interval, got.usec,
                                 got.count, got.bps);
                    end
                end
            end
        end
    end

    // Watchdog: too long with no transfer anywhere means the block is hung.
    always @(posedge clk)
    begin
        if ((pkt_if.valid && pkt_if.ready) || (rate_if.valid && rate_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_ts_bit_rate_between_pcr: errors");
            $finish;
        end
    end

endmodule
